// ===== design/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion unit
// CORDIC arctangent table, Q30 gain, data widths.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int TABLE_LEN = 24;
    localparam int Q30_W     = 33;   // signed Q30 with headroom for gain overshoot
    localparam int Z_W       = 34;   // half-angle accumulator, 2^31 is pi
    localparam int OUT_W     = 18;

    localparam logic signed [Q30_W-1:0] GAIN_Q30 = 33'sd652032874;

    typedef logic signed [Q30_W-1:0] t_q30;
    typedef logic signed [Z_W-1:0]   t_zang;
    typedef logic signed [OUT_W-1:0] t_q16;

    typedef struct packed {
        t_q30  x;
        t_q30  y;
        t_zang z;
    } t_rot;

    function automatic t_zang atan_at(input int i);
        t_zang r;
        case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/e2q_if.sv =====
// ----------------------------------------------------------------------------
// e2q_in_if / e2q_out_if: valid/ready channels of the unit
// A word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface e2q_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_about_x;
    logic signed [15:0] angle_about_y;
    logic signed [15:0] angle_about_z;
    modport source (output valid, angle_about_x, angle_about_y, angle_about_z,
                    input ready);
    modport sink   (input valid, angle_about_x, angle_about_y, angle_about_z,
                    output ready);
endinterface

interface e2q_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] component_zero;
    logic signed [17:0] component_one;
    logic signed [17:0] component_two;
    logic signed [17:0] component_three;
    modport source (output valid, component_zero, component_one, component_two,
                    component_three, input ready);
    modport sink   (input valid, component_zero, component_one, component_two,
                     component_three, output ready);
endinterface

// ===== design/e2q_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_cell: one CORDIC micro-rotation for three angles, registered
// Hands x/y/z of all three lanes to the next cell when the chain advances.
// ----------------------------------------------------------------------------
module e2q_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  e2q_pkg::t_rot    i_rot [3],
    output e2q_pkg::t_rot    o_rot [3]
);
    import e2q_pkg::*;

    t_rot r_rot [3];
    t_rot n_rot [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_rot[k].z[Z_W-1]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> STEP);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> STEP);
                n_rot[k].z = i_rot[k].z - atan_at(STEP);
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> STEP);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> STEP);
                n_rot[k].z = i_rot[k].z + atan_at(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;
endmodule

// ===== design/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// e2q_combine: pair products, triple products, round and saturate
// Three registered stages, stalled together with the chain.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic           i_clk,
    input  logic           i_en,
    input  e2q_pkg::t_q30  i_cx, i_sx, i_cy, i_sy, i_cz, i_sz,
    output e2q_pkg::t_q16  o_q [4]
);
    import e2q_pkg::*;

    localparam int PW = 2 * Q30_W;
    localparam int TW = 2 * Q30_W + 2;

    t_q30 r_p [6];
    t_q30 r_cy, r_sy, r_cz, r_sz;
    logic signed [TW-1:0] r_t [4];
    t_q16 r_q [4];
    logic signed [PW-1:0] w_prod [6];
    t_q30 w_pair [6];
    logic signed [TW-1:0] w_sum [4];
    t_q16 w_sat [4];

    function automatic t_q30 rnd30(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + (PW'(1) <<< 29)) >>> 30;
        return t[Q30_W-1:0];
    endfunction

    function automatic t_q16 fin(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] t;
        t = (v + (TW'(1) <<< 43)) >>> 44;
        if (t > TW'(131071))       return 18'sd131071;
        else if (t < -TW'(131072)) return -18'sd131072;
        return t[OUT_W-1:0];
    endfunction

    always_comb begin
        w_prod[0] = PW'(i_cx) * PW'(i_cy);
        w_prod[1] = PW'(i_sx) * PW'(i_sy);
        w_prod[2] = PW'(i_cz) * PW'(i_sx);
        w_prod[3] = PW'(i_sz) * PW'(i_cx);
        w_prod[4] = PW'(i_cz) * PW'(i_cx);
        w_prod[5] = PW'(i_sz) * PW'(i_sx);
        for (int k = 0; k < 6; k++) w_pair[k] = rnd30(w_prod[k]);
        w_sum[0] = TW'(r_sz) * TW'(r_p[0]) - TW'(r_cz) * TW'(r_p[1]);
        w_sum[1] = TW'(r_p[2]) * TW'(r_cy) + TW'(r_p[3]) * TW'(r_sy);
        w_sum[2] = TW'(r_p[4]) * TW'(r_sy) - TW'(r_p[5]) * TW'(r_cy);
        w_sum[3] = TW'(r_cz) * TW'(r_p[0]) + TW'(r_sz) * TW'(r_p[1]);
        for (int k = 0; k < 4; k++) w_sat[k] = fin(r_t[k]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_pair;
            r_cy <= i_cy; r_sy <= i_sy;
            r_cz <= i_cz; r_sz <= i_sz;
            r_t <= w_sum;
            r_q <= w_sat;
        end
    end

    assign o_q = r_q;
endmodule

// ===== design/euler_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit: Euler angles to unit quaternion
// Chain of CORDIC cells, product stages and an output register.
// ----------------------------------------------------------------------------
// Takes one word of three binary angles (2^(ANGLE_BITS-1) is pi) per cycle
// and returns one word of four signed Q1.16 quaternion components, scalar
// last. The pipe holds one entry register, one cell per CORDIC step and
// three product/rounding stages; throughput is one word per cycle while
// the cell chain advances, which it does unless stalled. The whole pipe
// stalls only when its last stage holds a word and the sink is not ready.
module euler_to_quaternion_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2q_in_if.sink    i_in,
    e2q_out_if.source o_out
);
    import e2q_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 4;

    // per-stage valid bits; the last one is the output word's valid
    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    t_rot             w_chain [CORDIC_STEPS+1][3];
    t_rot             r_entry [3];
    t_q16             w_q [4];
    t_zang            w_z [3];
    logic [Z_W-1:0]   w_raw [3];

    assign w_en       = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = w_en;

    // sign-extend the low ANGLE_BITS bits, scale so 2^31 is pi after halving
    always_comb begin
        w_raw[0] = Z_W'($unsigned(i_in.angle_about_x));
        w_raw[1] = Z_W'($unsigned(i_in.angle_about_y));
        w_raw[2] = Z_W'($unsigned(i_in.angle_about_z));
        for (int k = 0; k < 3; k++) begin
            w_z[k] = Z_W'($signed(w_raw[k][ANGLE_BITS-1:0])) <<< (31 - ANGLE_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_entry[k].x <= GAIN_Q30;
                r_entry[k].y <= '0;
                r_entry[k].z <= w_z[k];
            end
        end
    end

    assign w_chain[0] = r_entry;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2q_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rot (w_chain[g]),
            .o_rot (w_chain[g+1])
        );
    end

    e2q_combine u_comb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cx  (w_chain[CORDIC_STEPS][0].x),
        .i_sx  (w_chain[CORDIC_STEPS][0].y),
        .i_cy  (w_chain[CORDIC_STEPS][1].x),
        .i_sy  (w_chain[CORDIC_STEPS][1].y),
        .i_cz  (w_chain[CORDIC_STEPS][2].x),
        .i_sz  (w_chain[CORDIC_STEPS][2].y),
        .o_q   (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    assign o_out.valid           = r_vld[DEPTH-1];
    assign o_out.component_zero  = w_q[0];
    assign o_out.component_one   = w_q[1];
    assign o_out.component_two   = w_q[2];
    assign o_out.component_three = w_q[3];

    // a stalled output word keeps its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("output word dropped while stalled");
    // ready is low only when a word waits at the output
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input blocked with empty output");
    // an accepted word is tracked in the first stage's valid bit and moves on as the pipe advances
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && i_in.valid |=> r_vld[0])
        else $error("accepted word not tracked");
endmodule

// ===== verif/euler_to_quaternion_unit_test.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_test: testbench of the Euler-to-quaternion unit
// Drives angle words through the input channel, predicts each quaternion
// with a bit-exact CORDIC and product model, and checks every output word.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import e2q_pkg::*;

    localparam int STEPS      = 16;
    localparam int ABITS      = 16;
    localparam int LATENCY    = STEPS + 4;
    localparam int N_RANDOM   = 500;
    localparam int STALL_CAP  = 20000;   // idle cycles before giving up
    localparam longint GAIN   = 64'sd652032874;

    typedef struct {
        t_q16 c0;
        t_q16 c1;
        t_q16 c2;
        t_q16 c3;
    } t_quat;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 known;   // expected result typed in below
        t_quat              q;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    e2q_in_if  in_ch ();
    e2q_out_if out_ch ();

    euler_to_quaternion_unit #(.CORDIC_STEPS(STEPS), .ANGLE_BITS(ABITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_quat expected_quats[$];
    int    errors = 0;
    int    send_idle_pct = 15;
    int    recv_idle_pct = 69;
    bit    hold_recv = 1'b0;     // long sink hold-off, pipe fills and stalls input
    int    quiet_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---- predictor ---------------------------------------------------------
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;   // arithmetic shift of a signed value floors
    endfunction

    // sine and cosine of half the binary angle, both Q30
    function automatic void half_angle_trig(logic signed [15:0] raw,
                                            output longint c, output longint s);
        longint z, x, y, dx, dy;
        logic signed [ABITS-1:0] a;
        a = raw[ABITS-1:0];
        z = longint'(a) * (64'sd1 << (31 - ABITS));
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_at(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_at(i));
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint round_q30(longint p, longint q);
        return floor_shr(p * q + (64'sd1 << 29), 30);
    endfunction

    function automatic t_q16 to_q16(longint q60);
        longint v;
        v = floor_shr(q60 + (64'sd1 << 43), 44);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return t_q16'(v);
    endfunction

    function automatic t_quat euler_quat(logic signed [15:0] ax,
                                         logic signed [15:0] ay,
                                         logic signed [15:0] az);
        longint cx, sx, cy, sy, cz, sz;
        longint cxcy, sxsy, czsx, szcx, czcx, szsx;
        t_quat r;
        half_angle_trig(ax, cx, sx);
        half_angle_trig(ay, cy, sy);
        half_angle_trig(az, cz, sz);
        cxcy = round_q30(cx, cy);
        sxsy = round_q30(sx, sy);
        czsx = round_q30(cz, sx);
        szcx = round_q30(sz, cx);
        czcx = round_q30(cz, cx);
        szsx = round_q30(sz, sx);
        r.c0 = to_q16(sz * cxcy - cz * sxsy);
        r.c1 = to_q16(czsx * cy + szcx * sy);
        r.c2 = to_q16(czcx * sy - szsx * cy);
        r.c3 = to_q16(cz * cxcy + sz * sxsy);
        return r;
    endfunction

    // ---- directed rows -----------------------------------------------------
    // Zero angles, extremes, exactly -pi and bit patterns. The CORDIC leaves
    // a small residual angle even at zero, so the vector part of the zero row
    // is a few LSBs off the identity; every row goes through the predictor.
    t_row directed[] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0}},
        '{16'sh7fff,   16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0}},
        '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0}},
        '{16'sd0,      16'sh7fff,   16'sd0,      1'b0, '{0, 0, 0, 0}},
        '{16'sd0,      -16'sd32768, 16'sd0,      1'b0, '{0, 0, 0, 0}},
        '{16'sd0,      16'sd0,      16'sh7fff,   1'b0, '{0, 0, 0, 0}},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b0, '{0, 0, 0, 0}},
        '{16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b0, '{0, 0, 0, 0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{0, 0, 0, 0}},
        '{16'sd16384,  16'sd16384,  16'sd16384,  1'b0, '{0, 0, 0, 0}},
        '{-16'sd16384, 16'sd8192,   -16'sd8192,  1'b0, '{0, 0, 0, 0}},
        '{16'sd1,      -16'sd1,     16'sd1,      1'b0, '{0, 0, 0, 0}},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, '{0, 0, 0, 0}},
        '{16'sh5555,   16'shaaaa,   16'sh5555,   1'b0, '{0, 0, 0, 0}},
        '{16'shaaaa,   16'sh5555,   16'shaaaa,   1'b0, '{0, 0, 0, 0}},
        '{16'sd10923,  -16'sd21845, 16'sd5461,   1'b0, '{0, 0, 0, 0}}
    };

    // ---- sender ------------------------------------------------------------
    // valid stays high across back-to-back words; it drops only while idling
    // and at the end of a phase
    task automatic send_word(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.angle_about_x <= ax;
        in_ch.angle_about_y <= ay;
        in_ch.angle_about_z <= az;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Predictions are pushed at the accepting edge by the monitor below, so
    // typed-in expectations travel through the same queue.
    t_quat typed_quats[$];
    bit    typed_flags[$];

    task automatic send_row(t_row r);
        typed_flags.push_back(r.known);
        typed_quats.push_back(r.q);
        send_word(r.ax, r.ay, r.az);
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(4))
            0: return 16'sh7fff - 16'($urandom_range(3));
            1: return -16'sd32768 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        t_row r;
        for (int i = 0; i < n; i++) begin
            r.ax = random_angle();
            r.ay = random_angle();
            r.az = random_angle();
            r.known = 1'b0;
            send_row(r);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_quats.size() != 0 || typed_flags.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.angle_about_x = '0;
        in_ch.angle_about_y = '0;
        in_ch.angle_about_z = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) send_row(directed[k]);
        in_ch.valid <= 1'b0;

        // sender mostly busy, sink mostly stalled
        random_phase(N_RANDOM / 3);
        // long sink hold-off while words keep coming
        hold_recv = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            random_phase(2 * LATENCY);
        join
        send_idle_pct = 69;
        recv_idle_pct = 15;
        random_phase(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(N_RANDOM / 3);
        drain();

        if (errors == 0) begin
            $display("euler_to_quaternion_unit test passed");
        end else begin
            $display("euler_to_quaternion_unit test failed");
        end
        $finish;
    end

    // ---- receiver ----------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_recv) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---- monitor, checker and watchdog -------------------------------------
    always @(posedge i_clk) begin
        t_quat exp_q, got;
        bit    typed;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                typed = typed_flags.pop_front();
                exp_q = typed_quats.pop_front();
                if (!typed) begin
                    exp_q = euler_quat(in_ch.angle_about_x, in_ch.angle_about_y,
                                       in_ch.angle_about_z);
                end
                expected_quats.push_back(exp_q);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.component_zero, out_ch.component_one,
                        out_ch.component_two, out_ch.component_three};
                if (expected_quats.size() == 0) begin
                    $error("output word with nothing expected");
                    errors++;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (got.c0 !== exp_q.c0) begin
                        $error("component_zero: expected %0d, got %0d", exp_q.c0, got.c0);
                        errors++;
                    end
                    if (got.c1 !== exp_q.c1) begin
                        $error("component_one: expected %0d, got %0d", exp_q.c1, got.c1);
                        errors++;
                    end
                    if (got.c2 !== exp_q.c2) begin
                        $error("component_two: expected %0d, got %0d", exp_q.c2, got.c2);
                        errors++;
                    end
                    if (got.c3 !== exp_q.c3) begin
                        $error("component_three: expected %0d, got %0d", exp_q.c3, got.c3);
                        errors++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_CAP) begin
                $display("euler_to_quaternion_unit test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

// ===== files.f =====
design/e2q_pkg.sv
design/e2q_if.sv
design/e2q_cell.sv
design/e2q_combine.sv
design/euler_to_quaternion_unit.sv
verif/euler_to_quaternion_unit_test.sv
